// ----- rtl/wcs_pkg.sv -----
package wcs_pkg;

   localparam int TABLE_DEPTH   = 16;
   localparam int ID_BITS       = 16;
   localparam int COUNT_BITS    = 16;
   localparam int FRACTION_BITS = 16;

   localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
   localparam int ENTRY_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int TOTAL_BITS = COUNT_BITS + IDX_BITS;
   localparam int PROD_BITS  = TOTAL_BITS + FRACTION_BITS;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_SAT   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_SAMPLE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_BITS-1:0]   idx;
      logic [ID_BITS-1:0]    id;
      logic [COUNT_BITS-1:0] count;
   } table_wr_type;

endpackage

// ----- rtl/wcs_if.sv -----
interface wcs_req_if import wcs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [ID_BITS-1:0]       ctrl_id;
   logic [FRACTION_BITS-1:0] random_fraction;

   modport source (output valid, output op, output ctrl_id, output random_fraction,
                   input ready);
   modport sink   (input valid, input op, input ctrl_id, input random_fraction,
                   output ready);
endinterface

interface wcs_rsp_if import wcs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ID_BITS-1:0] sampled_id;
   logic [1:0]         status;

   modport source (output valid, output sampled_id, output status, input ready);
   modport sink   (input valid, input sampled_id, input status, output ready);
endinterface

// ----- rtl/wcs_table.sv -----
module wcs_table import wcs_pkg::*; (
   input  logic                  clock,
   input  table_wr_type          wr,
   input  logic [IDX_BITS-1:0]   rd_idx,
   output logic [ID_BITS-1:0]    rd_id,
   output logic [COUNT_BITS-1:0] rd_count
);

   logic [ID_BITS-1:0]    id_table_ff    [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] count_table_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         id_table_ff[wr.idx]    <= wr.id;
         count_table_ff[wr.idx] <= wr.count;
      end
   end

   assign rd_id    = id_table_ff[rd_idx];
   assign rd_count = count_table_ff[rd_idx];

endmodule

// ----- rtl/weighted_count_sampler_top.sv -----
// Weighted count sampler: keeps up to TABLE_DEPTH distinct identifiers with
// occurrence counts in insertion order. op 0 adds one occurrence of ctrl_id;
// op 1 draws an identifier with probability proportional to its count using
// random_fraction as a fraction of 2^FRACTION_BITS. Every request transaction
// yields exactly one response transaction. The block handles one request at
// a time: a single comparator walks the table one entry per cycle. An add
// walks until it finds ctrl_id or reaches the end of the table; a sample
// first forms the fraction times total product and then walks until the
// running sum exceeds it or the last entry is reached. req.ready is high
// only between requests, from the cycle after the response is loaded; a
// response may still be waiting on rsp while the next request is accepted.
module weighted_count_sampler_top import wcs_pkg::*; (
   input logic     clock,
   input logic     reset,
   wcs_req_if.sink   req,
   wcs_rsp_if.source rsp
);

   state_type                state_ff, state_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [FRACTION_BITS-1:0] frac_ff, frac_in;
   logic [ENTRY_BITS-1:0]    idx_ff, idx_in;
   logic [TOTAL_BITS-1:0]    cum_ff, cum_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [ENTRY_BITS-1:0]    entry_count_ff, entry_count_in;
   logic [TOTAL_BITS-1:0]    total_ff, total_in;
   logic [ID_BITS-1:0]       res_id_ff, res_id_in;
   status_type               res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   status_type               rsp_status_ff, rsp_status_in;

   table_wr_type             wr;
   logic [ID_BITS-1:0]       rd_id;
   logic [COUNT_BITS-1:0]    rd_count;
   logic [TOTAL_BITS-1:0]    cum_sum;
   logic                     at_end, is_last, id_match, hit, out_busy, sat;

   wcs_table u_table (
      .clock    (clock),
      .wr       (wr),
      .rd_idx   (idx_ff[IDX_BITS-1:0]),
      .rd_id    (rd_id),
      .rd_count (rd_count)
   );

   assign cum_sum  = cum_ff + TOTAL_BITS'(rd_count);
   assign at_end   = (idx_ff == entry_count_ff);
   assign is_last  = (idx_ff == entry_count_ff - ENTRY_BITS'(1));
   assign id_match = (rd_id == id_ff);
   assign hit      = (prod_ff < {cum_sum, {FRACTION_BITS{1'b0}}});
   assign sat      = (rd_count == {COUNT_BITS{1'b1}});
   assign out_busy = rsp_valid_ff && !rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (req.op == OP_ADD) begin
                  state_in = S_ADD;
               end else if (entry_count_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            state_in = S_SAMPLE;
         end
         S_ADD: begin
            if (at_end || id_match) begin
               state_in = S_FINISH;
            end
         end
         S_SAMPLE: begin
            if (hit || is_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req.ready      = 1'b0;
      id_in          = id_ff;
      frac_in        = frac_ff;
      idx_in         = idx_ff;
      cum_in         = cum_ff;
      prod_in        = prod_ff;
      entry_count_in = entry_count_ff;
      total_in       = total_ff;
      res_id_in      = res_id_ff;
      res_status_in  = res_status_ff;
      wr.en          = 1'b0;
      wr.idx         = idx_ff[IDX_BITS-1:0];
      wr.id          = id_ff;
      wr.count       = rd_count + COUNT_BITS'(1);
      unique case (state_ff)
         S_IDLE: begin
            req.ready     = 1'b1;
            id_in         = req.ctrl_id;
            frac_in       = req.random_fraction;
            idx_in        = '0;
            cum_in        = '0;
            res_id_in     = '0;
            res_status_in = (req.op == OP_SAMPLE && entry_count_ff == '0) ? ST_EMPTY : ST_OK;
         end
         S_MUL: begin
            prod_in = PROD_BITS'(frac_ff) * PROD_BITS'(total_ff);
         end
         S_ADD: begin
            if (at_end) begin
               if (entry_count_ff == ENTRY_BITS'(TABLE_DEPTH)) begin
                  res_status_in = ST_FULL;
               end else begin
                  wr.en          = 1'b1;
                  wr.count       = COUNT_BITS'(1);
                  entry_count_in = entry_count_ff + ENTRY_BITS'(1);
                  total_in       = total_ff + TOTAL_BITS'(1);
               end
            end else if (id_match) begin
               if (sat) begin
                  res_status_in = ST_SAT;
               end else begin
                  wr.en    = 1'b1;
                  total_in = total_ff + TOTAL_BITS'(1);
               end
            end else begin
               idx_in = idx_ff + ENTRY_BITS'(1);
            end
         end
         S_SAMPLE: begin
            if (hit || is_last) begin
               res_id_in = rd_id;
            end else begin
               cum_in = cum_sum;
               idx_in = idx_ff + ENTRY_BITS'(1);
            end
         end
         S_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_FINISH && !out_busy) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = res_id_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         total_ff       <= total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      frac_ff       <= frac_in;
      idx_ff        <= idx_in;
      cum_ff        <= cum_in;
      prod_ff       <= prod_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sampled_id = rsp_id_ff;
   assign rsp.status     = rsp_status_ff;

   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= ENTRY_BITS'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_total_covers_entries: assert property (@(posedge clock) disable iff (reset)
      total_ff >= TOTAL_BITS'(entry_count_ff))
      else $error("total count below number of entries");

   a_sample_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SAMPLE |-> idx_ff < entry_count_ff)
      else $error("sample walk past last entry");

   a_add_keeps_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SAMPLE |=> entry_count_ff == $past(entry_count_ff))
      else $error("entry count changed during sample");

endmodule
